### hdl/ookfe_pkg.sv
// ============================================================================
// ookfe_pkg
// Shared types and constants of the OOK remote-control frame encoder.
// ============================================================================
`default_nettype none

package ookfe_pkg;

    localparam int ADDRESS_BITS_DEFAULT = 8;
    localparam int DATA_BITS_DEFAULT    = 4;

    localparam int DUR_W   = 10;
    localparam int SHORT_W = 8;
    localparam int LONG_W  = 8;
    localparam int WORDS_W = 4;
    localparam int CFG_W   = 10;

    localparam logic [SHORT_W-1:0] SHORT_RESET    = 8'd4;
    localparam logic [LONG_W-1:0]  LONG_RESET     = 8'd12;
    localparam logic [DUR_W-1:0]   SYNC_LOW_RESET = 10'd128;
    localparam logic [WORDS_W-1:0] WORDS_RESET    = 4'd4;

    typedef enum logic [1:0] {
        CFG_SHORT    = 2'd0,
        CFG_LONG     = 2'd1,
        CFG_SYNC_LOW = 2'd2,
        CFG_WORDS    = 2'd3
    } cfg_index_t;

    typedef enum logic {
        ACT_START = 1'b0,
        ACT_TICK  = 1'b1
    } action_t;

endpackage

`default_nettype wire

### hdl/ook_remote_frame_encoder_top.sv
// ============================================================================
// ook_remote_frame_encoder_top
// Pulse-coded remote-control frame encoder driven by one request per tick.
// ============================================================================
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_stall, action, address,      | request in
//          | data_code                                 |
//  out     | out_valid, out_stall, line_level,         | result out
//          | busy_res, frame_done, start_rejected      |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | write in
//
//  One request per clock when not stalled; its result shows the next cycle.
//  The frame state advances in a single pass of logic from the state
//  registers into one output register.
//  Reset clears the frame state and loads the register defaults.
//  A request is taken while the output register is empty or being drained;
//  out_stall stalls the input only when a result is waiting.
// ============================================================================
`default_nettype none

module ook_remote_frame_encoder_top
    import ookfe_pkg::*;
#(
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEFAULT,
    parameter int DATA_BITS    = DATA_BITS_DEFAULT
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,

    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic                    action,
    input  wire logic [ADDRESS_BITS-1:0] address,
    input  wire logic [DATA_BITS-1:0]    data_code,

    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic                         line_level,
    output logic                         busy_res,
    output logic                         frame_done,
    output logic                         start_rejected,

    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [1:0]              cfg_index,
    input  wire logic [CFG_W-1:0]        cfg_data
);

    localparam int TOTAL_BITS = ADDRESS_BITS + DATA_BITS;
    localparam int SYM_W      = $clog2(TOTAL_BITS + 1);
    localparam int PAD_W      = 2 ** SYM_W;
    localparam logic [SYM_W-1:0] SYNC_IDX = SYM_W'(TOTAL_BITS);

    logic [SHORT_W-1:0]      short_reg;
    logic [LONG_W-1:0]       long_reg;
    logic [DUR_W-1:0]        sync_low_reg;
    logic [WORDS_W-1:0]      words_reg;

    logic                    sending_reg, sending_next;
    logic [ADDRESS_BITS-1:0] held_address_reg, held_address_next;
    logic [DATA_BITS-1:0]    held_code_reg, held_code_next;
    logic [WORDS_W-1:0]      word_reg, word_next;
    logic [SYM_W-1:0]        sym_reg, sym_next;
    logic [1:0]              seg_reg, seg_next;
    logic [DUR_W-1:0]        left_reg, left_next;

    logic                    out_valid_reg;
    logic                    level_reg, level_next;
    logic                    busy_reg;
    logic                    done_reg, done_next;
    logic                    rejected_reg, rejected_next;

    logic                    in_accept;
    logic                    out_accept;

    logic [DUR_W-1:0]        short_eff;
    logic [DUR_W-1:0]        long_eff;
    logic [DUR_W-1:0]        sync_low_eff;
    logic [WORDS_W-1:0]      words_eff;

    assign short_eff    = (short_reg == '0) ? DUR_W'(1) : DUR_W'(short_reg);
    assign long_eff     = (long_reg == '0) ? DUR_W'(1) : DUR_W'(long_reg);
    assign sync_low_eff = (sync_low_reg == '0) ? DUR_W'(1) : sync_low_reg;
    assign words_eff    = (words_reg == '0) ? WORDS_W'(1) : words_reg;

    assign cfg_ready  = 1'b1;
    assign out_accept = out_valid_reg && !out_stall;
    assign in_stall   = out_valid_reg && out_stall;
    assign in_accept  = in_valid && !in_stall;

    // Segment length for a symbol: data bit value, or sync when is_sync.
    function automatic logic [DUR_W-1:0] seg_length(
        input logic             is_sync,
        input logic             bit_val,
        input logic [1:0]       seg,
        input logic [DUR_W-1:0] s_len,
        input logic [DUR_W-1:0] l_len,
        input logic [DUR_W-1:0] sync_len
    );
        logic [DUR_W-1:0] len;
        if (is_sync)
        begin
            len = (seg == 2'd0) ? s_len : sync_len;
        end
        else if (bit_val == 1'b0)
        begin
            len = seg[0] ? l_len : s_len;
        end
        else
        begin
            len = seg[0] ? s_len : l_len;
        end
        return len;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_reg    <= SHORT_RESET;
            long_reg     <= LONG_RESET;
            sync_low_reg <= SYNC_LOW_RESET;
            words_reg    <= WORDS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SHORT:    short_reg    <= cfg_data[SHORT_W-1:0];
                CFG_LONG:     long_reg     <= cfg_data[LONG_W-1:0];
                CFG_SYNC_LOW: sync_low_reg <= cfg_data;
                CFG_WORDS:    words_reg    <= cfg_data[WORDS_W-1:0];
                default:      short_reg    <= short_reg;
            endcase
        end
    end

    always_comb
    begin
        logic [PAD_W-1:0]   bits_pad;
        logic [DUR_W-1:0]   left_dec;
        logic [1:0]         last_seg;
        logic [WORDS_W-1:0] word_inc;
        logic               next_is_sync;
        logic               next_bit;

        bits_pad     = PAD_W'({held_code_reg, held_address_reg});
        left_dec     = (left_reg != '0) ? left_reg - DUR_W'(1) : '0;
        last_seg     = (sym_reg == SYNC_IDX) ? 2'd1 : 2'd3;
        word_inc     = word_reg + WORDS_W'(1);
        next_is_sync = 1'b0;
        next_bit     = 1'b0;

        sending_next      = sending_reg;
        held_address_next = held_address_reg;
        held_code_next    = held_code_reg;
        word_next         = word_reg;
        sym_next          = sym_reg;
        seg_next          = seg_reg;
        left_next         = left_reg;
        level_next        = 1'b0;
        done_next         = 1'b0;
        rejected_next     = 1'b0;

        if (action == ACT_START)
        begin
            if (sending_reg)
            begin
                rejected_next = 1'b1;
            end
            else
            begin
                held_address_next = address;
                held_code_next    = data_code;
                sending_next      = 1'b1;
                word_next         = '0;
                sym_next          = '0;
                seg_next          = 2'd0;
                left_next         = seg_length(1'b0, address[0], 2'd0,
                                               short_eff, long_eff, sync_low_eff);
            end
        end
        else if (sending_reg)
        begin
            level_next = ~seg_reg[0];
            left_next  = left_dec;
            if (left_dec == '0)
            begin
                if (seg_reg < last_seg)
                begin
                    seg_next = seg_reg + 2'd1;
                end
                else
                begin
                    seg_next = 2'd0;
                    if (sym_reg < SYNC_IDX)
                    begin
                        sym_next = sym_reg + SYM_W'(1);
                    end
                    else
                    begin
                        sym_next = '0;
                        if (word_inc == '0 || word_inc >= words_eff)
                        begin
                            sending_next = 1'b0;
                            word_next    = '0;
                            done_next    = 1'b1;
                        end
                        else
                        begin
                            word_next = word_inc;
                        end
                    end
                end
                next_is_sync = (sym_next == SYNC_IDX);
                next_bit     = bits_pad[sym_next];
                if (sending_next)
                begin
                    left_next = seg_length(next_is_sync, next_bit, seg_next,
                                           short_eff, long_eff, sync_low_eff);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sending_reg      <= 1'b0;
            held_address_reg <= '0;
            held_code_reg    <= '0;
            word_reg         <= '0;
            sym_reg          <= '0;
            seg_reg          <= 2'd0;
            left_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                sending_reg      <= sending_next;
                held_address_reg <= held_address_next;
                held_code_reg    <= held_code_next;
                word_reg         <= word_next;
                sym_reg          <= sym_next;
                seg_reg          <= seg_next;
                left_reg         <= left_next;
                out_valid_reg    <= 1'b1;
            end
            else if (out_accept)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            level_reg    <= level_next;
            busy_reg     <= sending_next;
            done_reg     <= done_next;
            rejected_reg <= rejected_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign line_level     = level_reg;
    assign busy_res       = busy_reg;
    assign frame_done     = done_reg;
    assign start_rejected = rejected_reg;

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(done_reg && busy_reg))
        else $error("frame_done with busy_res set");

    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && rejected_reg |-> busy_reg && !level_reg)
        else $error("rejected start without a frame in progress");

    a_idle_word: assert property (@(posedge clk) disable iff (!rst_n)
        !sending_reg |-> word_reg == '0)
        else $error("word count left over while idle");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> out_valid_reg && $stable(busy_reg) && $stable(sending_reg))
        else $error("state moved while input stalled");

endmodule

`default_nettype wire
